### hw/rtl/ktk_pkg.sv
// Shared types, constants and helpers of the Kelvin traction kernel.
package ktk_pkg;

   localparam int unsigned MW = 40;            // multiplier operand width
   localparam int unsigned PW = 2 * MW;        // full product width
   localparam int unsigned QW = 48;            // width of rounded Q.30 results
   localparam int unsigned DW = 128;           // divider word width
   localparam logic [29:0] PI_Q28 = 30'd843314857;
   localparam logic [1:0] DIM_RESET = 2'd2;
   localparam logic [30:0] NU_RESET = 31'd322122547;
   localparam logic [1:0] DIM_3D = 2'd3;
   localparam logic REG_DIMENSION = 1'b0;
   localparam logic REG_POISSON = 1'b1;
   localparam int unsigned ENTRY_DEPTH_DEFAULT = 4;
   localparam int unsigned RESULT_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [31:0] distance;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
   } req_type;

   typedef struct packed {
      logic [1:0] row;
      logic [1:0] col;
      logic signed [63:0] value;
      logic saturated;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] row;
      logic [1:0] col;
      logic last;
      logic zero_r;
      logic is_3d;
      logic signed [63:0] bb;
      logic [DW-1:0] den;
   } entry_type;

   typedef enum logic [3:0] {
      FR_IDLE, FR_COS, FR_POM, FR_RSQ, FR_DEN,
      FR_RRIJ, FR_P1, FR_P2, FR_W, FR_T, FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_DIV, BK_OUT
   } back_state_type;

   // Q.30 rounding of a full product, ties away from zero
   function automatic logic signed [QW-1:0] qround(input logic signed [PW-1:0] p);
      logic [PW-1:0] mag;
      logic [PW-1:0] m;
      mag = p[PW-1] ? -p : p;
      m = (mag + (PW'(1) << 29)) >> 30;
      return p[PW-1] ? $signed(QW'(-m)) : $signed(QW'(m));
   endfunction

endpackage

### hw/rtl/kelvin_traction_kernel.sv
// Top level of the Kelvin traction kernel: registers, front end, queues, divider.
//
// Input channel: push/full with req_data (distance Q16.16, unit distance and
// normal vectors Q2.30). Result channel: empty/pop with rsp_data, one kernel
// entry T_ij (Q32.32) per transfer in row-major order, last set on the final
// entry; 4 entries in 2D, 9 in 3D.
// Configuration: APB-style port, dimension at 0x0 and poisson_ratio at 0x4.
// The front end runs every product through one shared multiplier, in a phase
// that registers the product and a phase that uses it. It hands finished
// entries to a short queue and then takes the next item. The divider retires
// one quotient bit a cycle over a 128-bit word and sets the sustained rate;
// an entry at zero distance skips the division and is flagged saturated.
// Reset empties both queues, idles both ends and loads dimension 2 and
// poisson_ratio 0.3. When the receiver stops popping, the result queue
// fills, the divider holds its finished entry, the entry queue fills and
// the front end stalls; full then stays high.
module kelvin_traction_kernel #(
   parameter int unsigned ENTRY_DEPTH = ktk_pkg::ENTRY_DEPTH_DEFAULT,
   parameter int unsigned RESULT_DEPTH = ktk_pkg::RESULT_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  ktk_pkg::req_type req_data,
   output logic empty,
   input  logic pop,
   output ktk_pkg::rsp_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   logic [1:0] dim_ff;
   logic [30:0] nu_ff;
   logic csr_write;

   logic entry_push, entry_full, entry_pop, entry_empty;
   ktk_pkg::entry_type entry_wr, entry_rd;
   logic out_push, out_full;
   ktk_pkg::rsp_type out_wr;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == ktk_pkg::REG_POISSON) ? {1'b0, nu_ff} : {30'b0, dim_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= ktk_pkg::DIM_RESET;
         nu_ff <= ktk_pkg::NU_RESET;
      end else if (csr_write) begin
         if (paddr[2] == ktk_pkg::REG_POISSON) nu_ff <= pwdata[30:0];
         else dim_ff <= pwdata[1:0];
      end
   end

   ktk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .is_3d      (dim_ff == ktk_pkg::DIM_3D),
      .nu         ($signed(nu_ff)),
      .entry_push (entry_push),
      .entry_full (entry_full),
      .entry_data (entry_wr)
   );

   ktk_queue #(
      .WIDTH ($bits(ktk_pkg::entry_type)),
      .DEPTH (ENTRY_DEPTH)
   ) u_entry_q (
      .clock (clock),
      .reset (reset),
      .push  (entry_push),
      .full  (entry_full),
      .wdata (entry_wr),
      .pop   (entry_pop),
      .empty (entry_empty),
      .rdata (entry_rd)
   );

   ktk_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_empty (entry_empty),
      .entry_pop   (entry_pop),
      .entry_data  (entry_rd),
      .out_push    (out_push),
      .out_full    (out_full),
      .out_data    (out_wr)
   );

   ktk_queue #(
      .WIDTH ($bits(ktk_pkg::rsp_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (out_wr),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_data)
   );
endmodule

### hw/rtl/ktk_queue.sv
// Small first-word-fall-through queue.
module ktk_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [WIDTH-1:0] wdata,
   input  logic pop,
   output logic empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int unsigned AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0] wr_ff, wr_in, rd_ff, rd_in;

   assign full = (wr_ff[AW] != rd_ff[AW]) && (wr_ff[AW-1:0] == rd_ff[AW-1:0]);
   assign empty = (wr_ff == rd_ff);
   assign rdata = mem_ff[rd_ff[AW-1:0]];
   assign wr_in = wr_ff + (AW+1)'(push && !full);
   assign rd_in = rd_ff + (AW+1)'(pop && !empty);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff[AW-1:0]] <= wdata;
      end
   end
endmodule

### hw/rtl/ktk_front.sv
// Front end: accepts geometry, forms the numerator terms and the denominator.
module ktk_front (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  ktk_pkg::req_type req_data,
   input  logic is_3d,
   input  logic signed [30:0] nu,
   output logic entry_push,
   input  logic entry_full,
   output ktk_pkg::entry_type entry_data
);
   localparam int unsigned MW = ktk_pkg::MW;
   localparam int unsigned QW = ktk_pkg::QW;

   ktk_pkg::front_state_type state_ff, state_in;
   logic ph_ff;
   logic [1:0] k_ff, i_ff, j_ff;
   logic signed [31:0] dv_ff [3];
   logic signed [31:0] nv_ff [3];
   logic [31:0] r_ff;
   logic d3_ff;
   logic signed [33:0] c3_ff;
   logic [31:0] om_ff;
   logic signed [2*MW-1:0] prod_ff;
   logic signed [QW-1:0] cos_ff, a_ff, p1_ff, diff_ff, w_ff;
   logic [61:0] pom_ff;
   logic [63:0] rsq_ff;
   logic [ktk_pkg::DW-1:0] den_ff;
   logic signed [63:0] bb_ff;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [QW-1:0] q;
   logic [1:0] idx_max;
   logic entry_last, mul_state;
   logic [ktk_pkg::DW-1:0] part;

   function automatic logic signed [31:0] pick(input logic signed [31:0] v0,
                                               input logic signed [31:0] v1,
                                               input logic signed [31:0] v2,
                                               input logic [1:0] idx);
      logic signed [31:0] res;
      case (idx)
         2'd0: res = v0;
         2'd1: res = v1;
         default: res = v2;
      endcase
      return res;
   endfunction

   assign q = ktk_pkg::qround(prod_ff);
   assign idx_max = d3_ff ? 2'd2 : 2'd1;
   assign entry_last = (i_ff == idx_max) && (j_ff == idx_max);
   assign mul_state = (state_ff != ktk_pkg::FR_IDLE) && (state_ff != ktk_pkg::FR_PUSH);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ktk_pkg::FR_COS: begin
            mul_a = MW'(pick(nv_ff[0], nv_ff[1], nv_ff[2], k_ff));
            mul_b = MW'(pick(dv_ff[0], dv_ff[1], dv_ff[2], k_ff));
         end
         ktk_pkg::FR_POM: begin
            mul_a = $signed({10'b0, ktk_pkg::PI_Q28});
            mul_b = $signed({8'b0, om_ff});
         end
         ktk_pkg::FR_RSQ: begin
            mul_a = $signed({8'b0, r_ff});
            mul_b = $signed({8'b0, r_ff});
         end
         ktk_pkg::FR_DEN: begin
            mul_a = k_ff[1] ? $signed({10'b0, pom_ff[61:32]}) : $signed({8'b0, pom_ff[31:0]});
            mul_b = k_ff[0] ? $signed({8'b0, rsq_ff[63:32]}) : $signed({8'b0, rsq_ff[31:0]});
         end
         ktk_pkg::FR_RRIJ: begin
            mul_a = MW'(pick(dv_ff[0], dv_ff[1], dv_ff[2], i_ff));
            mul_b = MW'(pick(dv_ff[0], dv_ff[1], dv_ff[2], j_ff));
         end
         ktk_pkg::FR_P1: begin
            mul_a = MW'(pick(nv_ff[0], nv_ff[1], nv_ff[2], j_ff));
            mul_b = MW'(pick(dv_ff[0], dv_ff[1], dv_ff[2], i_ff));
         end
         ktk_pkg::FR_P2: begin
            mul_a = MW'(pick(nv_ff[0], nv_ff[1], nv_ff[2], i_ff));
            mul_b = MW'(pick(dv_ff[0], dv_ff[1], dv_ff[2], j_ff));
         end
         ktk_pkg::FR_W: begin
            mul_a = MW'(c3_ff);
            mul_b = MW'(diff_ff);
         end
         ktk_pkg::FR_T: begin
            mul_a = MW'(cos_ff);
            mul_b = MW'(a_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (k_ff)
         2'd0: part = ktk_pkg::DW'(prod_ff[63:0]);
         2'd3: part = ktk_pkg::DW'(prod_ff[63:0]) << 64;
         default: part = ktk_pkg::DW'(prod_ff[63:0]) << 32;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ktk_pkg::FR_IDLE: if (push) state_in = ktk_pkg::FR_COS;
         ktk_pkg::FR_COS: if (ph_ff && k_ff == idx_max) state_in = ktk_pkg::FR_POM;
         ktk_pkg::FR_POM: if (ph_ff) state_in = d3_ff ? ktk_pkg::FR_RSQ : ktk_pkg::FR_DEN;
         ktk_pkg::FR_RSQ: if (ph_ff) state_in = ktk_pkg::FR_DEN;
         ktk_pkg::FR_DEN: if (ph_ff && k_ff == 2'd3) state_in = ktk_pkg::FR_RRIJ;
         ktk_pkg::FR_RRIJ: if (ph_ff) state_in = ktk_pkg::FR_P1;
         ktk_pkg::FR_P1: if (ph_ff) state_in = ktk_pkg::FR_P2;
         ktk_pkg::FR_P2: if (ph_ff) state_in = ktk_pkg::FR_W;
         ktk_pkg::FR_W: if (ph_ff) state_in = ktk_pkg::FR_T;
         ktk_pkg::FR_T: if (ph_ff) state_in = ktk_pkg::FR_PUSH;
         ktk_pkg::FR_PUSH: begin
            if (!entry_full) state_in = entry_last ? ktk_pkg::FR_IDLE : ktk_pkg::FR_RRIJ;
         end
         default: state_in = ktk_pkg::FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      full = (state_ff != ktk_pkg::FR_IDLE);
      entry_push = (state_ff == ktk_pkg::FR_PUSH);
      entry_data.row = i_ff;
      entry_data.col = j_ff;
      entry_data.last = entry_last;
      entry_data.zero_r = (r_ff == 32'd0);
      entry_data.is_3d = d3_ff;
      entry_data.bb = bb_ff;
      entry_data.den = den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ktk_pkg::FR_IDLE;
         ph_ff <= 1'b0;
         k_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff <= mul_state && !ph_ff;
         if (state_ff == ktk_pkg::FR_IDLE) begin
            k_ff <= '0;
            i_ff <= '0;
            j_ff <= '0;
         end else if (ph_ff && (state_ff == ktk_pkg::FR_COS || state_ff == ktk_pkg::FR_DEN)) begin
            k_ff <= (state_in != state_ff) ? 2'd0 : k_ff + 2'd1;
         end else if (state_ff == ktk_pkg::FR_PUSH && !entry_full) begin
            if (j_ff == idx_max) begin
               j_ff <= '0;
               i_ff <= i_ff + 2'd1;
            end else begin
               j_ff <= j_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ktk_pkg::FR_IDLE && push) begin
         r_ff <= req_data.distance;
         d3_ff <= is_3d;
         dv_ff[0] <= req_data.dir_x;
         dv_ff[1] <= req_data.dir_y;
         dv_ff[2] <= req_data.dir_z;
         nv_ff[0] <= req_data.norm_x;
         nv_ff[1] <= req_data.norm_y;
         nv_ff[2] <= req_data.norm_z;
         c3_ff <= 34'sh40000000 - (34'(nu) <<< 1);
         om_ff <= 32'(33'sh40000000 - 33'(nu));
         cos_ff <= '0;
         den_ff <= '0;
      end
      if (!ph_ff) begin
         prod_ff <= mul_a * mul_b;
      end else begin
         case (state_ff)
            ktk_pkg::FR_COS: cos_ff <= cos_ff + q;
            ktk_pkg::FR_POM: begin
               pom_ff <= prod_ff[61:0];
               if (!d3_ff) rsq_ff <= {32'b0, r_ff};
            end
            ktk_pkg::FR_RSQ: rsq_ff <= prod_ff[63:0];
            ktk_pkg::FR_DEN: den_ff <= den_ff + part;
            ktk_pkg::FR_RRIJ: begin
               a_ff <= ((i_ff == j_ff) ? QW'(c3_ff) : '0) + (q <<< 1) + (d3_ff ? q : '0);
            end
            ktk_pkg::FR_P1: p1_ff <= q;
            ktk_pkg::FR_P2: diff_ff <= p1_ff - q;
            ktk_pkg::FR_W: w_ff <= q;
            ktk_pkg::FR_T: bb_ff <= 64'(q - w_ff);
            default: bb_ff <= bb_ff;
         endcase
      end
   end
endmodule

### hw/rtl/ktk_back.sv
// Back end: scales each entry by the denominator with a radix-2 divider.
module ktk_back (
   input  logic clock,
   input  logic reset,
   input  logic entry_empty,
   output logic entry_pop,
   input  ktk_pkg::entry_type entry_data,
   output logic out_push,
   input  logic out_full,
   output ktk_pkg::rsp_type out_data
);
   localparam int unsigned DW = ktk_pkg::DW;

   ktk_pkg::back_state_type state_ff, state_in;
   logic [DW-1:0] num_ff, rem_ff, quo_ff, den_ff;
   logic [$clog2(DW)-1:0] cnt_ff;
   logic neg_ff;
   ktk_pkg::rsp_type res_ff;

   logic [63:0] mag, limit, qv;
   logic in_neg, ge, ovf;
   logic [DW-1:0] num0, rem_sh, rem_next, quo_next;

   assign in_neg = (entry_data.bb > 64'sd0);
   assign mag = entry_data.bb[63] ? 64'(-entry_data.bb) : 64'(entry_data.bb);
   assign num0 = {(mag << (entry_data.is_3d ? 25 : 10)), 64'b0} + {1'b0, entry_data.den[DW-1:1]};
   assign rem_sh = {rem_ff[DW-2:0], num_ff[DW-1]};
   assign ge = (rem_sh >= den_ff);
   assign rem_next = ge ? rem_sh - den_ff : rem_sh;
   assign quo_next = {quo_ff[DW-2:0], ge};
   assign limit = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
   assign ovf = (quo_next[DW-1:64] != '0) || (quo_next[63:0] > limit);
   assign qv = ovf ? limit : quo_next[63:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ktk_pkg::BK_IDLE: begin
            if (!entry_empty) state_in = entry_data.zero_r ? ktk_pkg::BK_OUT : ktk_pkg::BK_DIV;
         end
         ktk_pkg::BK_DIV: if (cnt_ff == '0) state_in = ktk_pkg::BK_OUT;
         ktk_pkg::BK_OUT: if (!out_full) state_in = ktk_pkg::BK_IDLE;
         default: state_in = ktk_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      entry_pop = (state_ff == ktk_pkg::BK_IDLE) && !entry_empty;
      out_push = (state_ff == ktk_pkg::BK_OUT);
      out_data = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ktk_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         num_ff <= num0;
         rem_ff <= '0;
         quo_ff <= '0;
         den_ff <= entry_data.den;
         cnt_ff <= '1;
         neg_ff <= in_neg;
         res_ff.row <= entry_data.row;
         res_ff.col <= entry_data.col;
         res_ff.last <= entry_data.last;
         res_ff.saturated <= entry_data.zero_r;
         // zero distance: pin to the limit opposite the numerator sign
         if (in_neg) res_ff.value <= 64'sh8000_0000_0000_0000;
         else if (entry_data.bb[63]) res_ff.value <= 64'sh7fff_ffff_ffff_ffff;
         else res_ff.value <= '0;
      end else if (state_ff == ktk_pkg::BK_DIV) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_next;
         quo_ff <= quo_next;
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            res_ff.saturated <= ovf;
            res_ff.value <= neg_ff ? $signed(-qv) : $signed(qv);
         end
      end
   end

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ktk_pkg::BK_DIV) |-> (den_ff != '0))
      else $error("divider running with zero denominator");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ktk_pkg::BK_DIV) |-> (rem_ff < den_ff))
      else $error("partial remainder not below denominator");

   a_out_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ktk_pkg::BK_OUT && !out_full) |=> (state_ff == ktk_pkg::BK_IDLE))
      else $error("result transfer did not release the divider");
endmodule
